// ===== rtl/core/gwo_pkg.sv =====
// Shared types, constants and helpers for the glyph wander offset core.
package gwo_pkg;

  localparam int INDEX_WIDTH_DEF = 16;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_HOP_SPEED     = 3'd0;
  localparam logic [2:0] REG_EASE_MODE     = 3'd1;
  localparam logic [2:0] REG_WANDER_RADIUS = 3'd2;
  localparam logic [2:0] REG_LOOP_ENABLE   = 3'd3;
  localparam logic [2:0] REG_SHAKE_LENGTH  = 3'd4;
  localparam logic [2:0] REG_REST_LENGTH   = 3'd5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [10:0] SPEED_MIN = 11'd13;
  localparam logic [19:0] SHAKE_MIN = 20'd6554;

  // Hash multipliers
  localparam logic [31:0] HASH_A = 32'd2654435761;
  localparam logic [31:0] HASH_B = 32'd2246822519;
  localparam logic [31:0] HASH_C = 32'd374761393;
  localparam logic [31:0] HASH_D = 32'd1274126177;

  // Ease-out-back coefficients, Q16
  localparam logic [17:0] EASE_C3 = 18'd177051;
  localparam logic [16:0] EASE_C1 = 17'd111515;

  // Reciprocals of 7: ceil(2^35/7) for 32-bit values, ceil(2^20/7) for 18-bit values
  localparam logic [32:0] DIV7_M  = 33'd4908534053;
  localparam logic [17:0] DIV7_M2 = 18'd149797;

  typedef struct packed {
    logic [15:0] glyph_index;
    logic [31:0] frame_time;
  } in_t;

  typedef struct packed {
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic [16:0]        envelope;
  } out_t;

  // Four restoring remainder steps: shifts in one nibble of the dividend
  function automatic logic [20:0] mod_nib(input logic [20:0] rem, input logic [3:0] nib,
                                          input logic [20:0] per);
    logic [21:0] r;
    r = {1'b0, rem};
    for (int j = 3; j >= 0; j--) begin
      r = {r[20:0], nib[j]};
      if (r >= {1'b0, per}) begin
        r = r - {1'b0, per};
      end
    end
    return r[20:0];
  endfunction

endpackage

// ===== rtl/core/glyph_wander_offset_core.sv =====
// Glyph wander offset core: hashed value noise path with ease and shake envelope.
// A word accepted on the input passes stages S0 to S13 and then shows on out_valid_o.
// Throughput: one word per cycle unless an output stall backs up to the input; the 14-stage
// pipeline collapses bubbles, so a stalled output only holds stages that are full.
// The time modulo for the envelope is a restoring remainder, 4 bits per stage.
// Reset (async, active low) clears all valid bits and loads register defaults.
module glyph_wander_offset_core #(
  parameter int INDEX_WIDTH = gwo_pkg::INDEX_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gwo_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [gwo_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  gwo_pkg::in_t                    in_word_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output gwo_pkg::out_t                   out_word_o
);
  import gwo_pkg::*;

  localparam int NSTG       = 14;
  localparam int MOD_STAGES = 8;

  // Superset of all stage fields; each stage fills its own, the rest ride along.
  typedef struct packed {
    logic [15:0]       g;
    logic [31:0]       t;
    logic [20:0]       rem;
    logic [29:0]       q;
    logic [45:0]       qs;
    logic [17:0]       rs;
    logic [35:0]       rm;
    logic [47:0]       f;
    logic [15:0]       p;
    logic [16:0]       a;
    logic [16:0]       a2;
    logic [16:0]       a3;
    logic [34:0]       m3;
    logic [33:0]       m1;
    logic [31:0]       ga;
    logic [31:0]       hb;
    logic [3:0][31:0]  h;
    logic [3:0][23:0]  tg;
    logic [20:0]       w;
    logic [1:0][45:0]  dw;
    logic [1:0][27:0]  b;
    logic [1:0][43:0]  br;
    logic [1:0][41:0]  ph;
    logic [1:0][36:0]  pl;
    logic [16:0]       env;
    out_t              res;
  } pipe_t;

  // Configuration registers
  logic [10:0] hop_speed_q;
  logic        ease_mode_q;
  logic [14:0] wander_radius_q;
  logic        loop_enable_q;
  logic [19:0] shake_length_q;
  logic [19:0] rest_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hop_speed_q     <= 11'd256;
      ease_mode_q     <= 1'b0;
      wander_radius_q <= 15'd2048;
      loop_enable_q   <= 1'b0;
      shake_length_q  <= 20'd131072;
      rest_length_q   <= 20'd98304;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HOP_SPEED:     hop_speed_q     <= cfg_data_i[10:0];
        REG_EASE_MODE:     ease_mode_q     <= cfg_data_i[0];
        REG_WANDER_RADIUS: wander_radius_q <= cfg_data_i[14:0];
        REG_LOOP_ENABLE:   loop_enable_q   <= cfg_data_i[0];
        REG_SHAKE_LENGTH:  shake_length_q  <= cfg_data_i[19:0];
        REG_REST_LENGTH:   rest_length_q   <= cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  // Derived config; the user must keep it static while words are in flight, the block does not enforce it
  logic [10:0] speed;
  logic [15:0] sp20;
  logic [19:0] act;
  logic [20:0] period;

  assign speed  = (hop_speed_q < SPEED_MIN) ? SPEED_MIN : hop_speed_q;
  assign sp20   = 16'(speed * 16'd20);
  assign act    = (shake_length_q < SHAKE_MIN) ? SHAKE_MIN : shake_length_q;
  assign period = 21'(act) + 21'(rest_length_q);

  // Glyph mask from INDEX_WIDTH
  logic [15:0] g_in;
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      g_in[i] = (i < INDEX_WIDTH) ? in_word_i.glyph_index[i] : 1'b0;
    end
  end

  // Pipeline control: a stage loads when empty or when its successor moves
  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] ready;
  pipe_t           pipe_q [NSTG];
  pipe_t           pipe_d [NSTG];

  always_comb begin
    ready[NSTG-1] = !v_q[NSTG-1] || !out_stall_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      ready[k] = !v_q[k] || ready[k+1];
    end
  end

  assign in_stall_o  = !ready[0];
  assign out_valid_o = v_q[NSTG-1];
  assign out_word_o  = pipe_q[NSTG-1].res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ready[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (ready[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NSTG; k++) begin
      if (ready[k]) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

  // Datapath
  always_comb begin
    logic [64:0]        qp;
    logic [2:0]         r7;
    logic [31:0]        hs;
    logic signed [20:0] ws;
    logic signed [24:0] dlt;
    logic [21:0]        up;
    logic [21:0]        down;
    logic [16:0]        e;
    logic signed [61:0] sum;
    logic signed [22:0] rnd;

    for (int k = 1; k < NSTG; k++) begin
      pipe_d[k] = pipe_q[k-1];
    end

    // S0: input capture
    pipe_d[0]     = '0;
    pipe_d[0].g   = g_in;
    pipe_d[0].t   = in_word_i.frame_time;
    pipe_d[0].rem = '0;

    // S1..S8: time modulo period, one nibble per stage
    for (int k = 1; k <= MOD_STAGES; k++) begin
      pipe_d[k].rem = mod_nib(pipe_q[k-1].rem, pipe_q[k-1].t[35-4*k -: 4], period);
    end

    // S1: q = t / 7
    qp          = 65'(pipe_q[0].t) * 65'(DIV7_M);
    pipe_d[1].q = qp[64:35];

    // S2: split t*sp20 into q*sp20 + r*sp20
    r7           = 3'(pipe_q[1].t - 32'(pipe_q[1].q) * 32'd7);
    pipe_d[2].qs = 46'(pipe_q[1].q) * 46'(sp20);
    pipe_d[2].rs = 18'(r7) * 18'(sp20);

    // S3: r*sp20 / 7 via reciprocal
    pipe_d[3].rm = 36'(pipe_q[2].rs) * 36'(DIV7_M2);

    // S4: hop position, Q.24
    pipe_d[4].f = pipe_q[3].qs + 48'(pipe_q[3].rm[35:20]);

    // S5: split hop and phase; first hash products and a^2
    pipe_d[5].p  = pipe_q[4].f[23:8];
    pipe_d[5].a  = 17'(18'd65536 - 18'(pipe_q[4].f[23:8]));
    pipe_d[5].a2 = 17'((34'(pipe_d[5].a) * 34'(pipe_d[5].a)) >> 16);
    pipe_d[5].ga = 32'(32'(pipe_q[4].g) * HASH_A);
    pipe_d[5].hb = 32'(32'(pipe_q[4].f[47:24]) * HASH_B);

    // S6: hash sums (index = axis*2 + next hop) and a^3
    for (int i = 0; i < 4; i++) begin
      hs = pipe_q[5].ga + pipe_q[5].hb + (i[0] ? HASH_B : 32'd0) + (i[1] ? HASH_C : 32'd0);
      pipe_d[6].h[i] = hs ^ (hs >> 13);
    end
    pipe_d[6].a3 = 17'((34'(pipe_q[5].a2) * 34'(pipe_q[5].a)) >> 16);

    // S7: hash multiply, ease products
    for (int i = 0; i < 4; i++) begin
      pipe_d[7].h[i] = 32'(pipe_q[6].h[i] * HASH_D);
    end
    pipe_d[7].m3 = 35'(pipe_q[6].a3) * 35'(EASE_C3);
    pipe_d[7].m1 = 34'(pipe_q[6].a2) * 34'(EASE_C1);

    // S8: targets in Q1.23 (flip of bit 23 subtracts 2^23), weight
    for (int i = 0; i < 4; i++) begin
      hs = pipe_q[7].h[i] ^ (pipe_q[7].h[i] >> 16);
      pipe_d[8].tg[i] = {~hs[23], hs[22:0]};
    end
    if (ease_mode_q) begin
      ws = 21'sd65536 - $signed(21'(pipe_q[7].m3[34:16]))
                      + $signed(21'(pipe_q[7].m1[33:16]));
    end else begin
      ws = $signed(21'(pipe_q[7].p));
    end
    pipe_d[8].w = ws;

    // S9: delta times weight, envelope from the remainder
    for (int ax = 0; ax < 2; ax++) begin
      dlt = 25'($signed(pipe_q[8].tg[2*ax+1])) - 25'($signed(pipe_q[8].tg[2*ax]));
      pipe_d[9].dw[ax] = 46'($signed(dlt) * $signed(pipe_q[8].w));
    end
    up   = {pipe_q[8].rem[19:0], 2'b00};
    down = {20'(act - pipe_q[8].rem[19:0]), 2'b00};
    e    = 17'd65536;
    if (up < 22'(e)) begin
      e = up[16:0];
    end
    if (down < 22'(e)) begin
      e = down[16:0];
    end
    if (!loop_enable_q) begin
      pipe_d[9].env = 17'd65536;
    end else if (pipe_q[8].rem >= 21'(act)) begin
      pipe_d[9].env = '0;
    end else begin
      pipe_d[9].env = e;
    end

    // S10: blend, floor shift
    for (int ax = 0; ax < 2; ax++) begin
      pipe_d[10].b[ax] = 28'($signed(pipe_q[9].tg[2*ax])
                       + 28'($signed(pipe_q[9].dw[ax]) >>> 16));
    end

    // S11: radius
    for (int ax = 0; ax < 2; ax++) begin
      pipe_d[11].br[ax] = 44'($signed(pipe_q[10].b[ax]) *
                              $signed({1'b0, wander_radius_q}));
    end

    // S12: envelope product in two partials
    for (int ax = 0; ax < 2; ax++) begin
      pipe_d[12].ph[ax] = 42'($signed(pipe_q[11].br[ax][43:20]) *
                              $signed({1'b0, pipe_q[11].env}));
      pipe_d[12].pl[ax] = 37'(pipe_q[11].br[ax][19:0]) * 37'(pipe_q[11].env);
    end

    // S13: round half up, saturate
    pipe_d[13].res.envelope = pipe_q[12].env;
    pipe_d[13].res.offset_x = '0;
    pipe_d[13].res.offset_y = '0;
    for (int ax = 0; ax < 2; ax++) begin
      sum = ($signed(62'($signed(pipe_q[12].ph[ax]))) <<< 20)
          + $signed(62'(pipe_q[12].pl[ax])) + 62'sd274877906944;
      rnd = 23'(sum >>> 39);
      if (rnd > 23'sd32767) begin
        rnd = 23'sd32767;
      end else if (rnd < -23'sd32768) begin
        rnd = -23'sd32768;
      end
      if (ax == 0) begin
        pipe_d[13].res.offset_x = rnd[15:0];
      end else begin
        pipe_d[13].res.offset_y = rnd[15:0];
      end
    end
  end

endmodule

// ===== bench/glyph_wander_offset_checker.sv =====
// Checker for the glyph wander offset core: predicts each word and compares results.
module glyph_wander_offset_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [19:0]   cfg_data_i,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  gwo_pkg::in_t  in_word_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  gwo_pkg::out_t out_word_i,
  output int            fail_count_o,
  output int            checked_o
);
  import gwo_pkg::*;

  logic [10:0] speed_q;
  logic        ease_q;
  logic [14:0] radius_q;
  logic        loop_q;
  logic [19:0] shake_q;
  logic [19:0] rest_q;

  out_t offset_queue[$];
  int   fails;
  int   checked;

  assign fail_count_o = fails;
  assign checked_o    = checked;

  // Hashed target, Q1.23
  function automatic longint noise_target(logic [31:0] g, logic [31:0] hop, logic [31:0] axis);
    logic [31:0] h;
    h = g * HASH_A + hop * HASH_B + axis * HASH_C;
    h = h ^ (h >> 13);
    h = h * HASH_D;
    h = h ^ (h >> 16);
    return longint'({8'd0, h[23:0]}) - 64'sh800000;
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic out_t wander_offset(in_t w);
    out_t        r;
    logic [63:0] sp, f, a, a2, a3, act, ct, e;
    logic [31:0] hop;
    longint      wt, env, r0, r1, b, prod;
    sp  = (speed_q < SPEED_MIN) ? 64'(SPEED_MIN) : 64'(speed_q);
    f   = (64'(w.frame_time) * sp * 64'd20) / 64'd7;
    hop = f[55:24];
    wt  = longint'(f[23:8]);
    if (ease_q) begin
      a  = 64'd65536 - 64'(wt);
      a2 = (a * a) >> 16;
      a3 = (a2 * a) >> 16;
      wt = 65536 - longint'((64'd177051 * a3) >> 16) + longint'((64'd111515 * a2) >> 16);
    end
    env = 65536;
    if (loop_q) begin
      act = (shake_q < SHAKE_MIN) ? 64'(SHAKE_MIN) : 64'(shake_q);
      ct  = 64'(w.frame_time) % (act + 64'(rest_q));
      if (ct >= act) env = 0;
      else begin
        e = 65536;
        if (ct * 4 < e) e = ct * 4;
        if ((act - ct) * 4 < e) e = (act - ct) * 4;
        env = longint'(e);
      end
    end
    for (int axis = 0; axis < 2; axis++) begin
      r0   = noise_target(32'(w.glyph_index), hop, axis);
      r1   = noise_target(32'(w.glyph_index), hop + 32'd1, axis);
      b    = r0 + (((r1 - r0) * wt) >>> 16);
      prod = b * longint'(radius_q) * env;
      if (axis == 0) r.offset_x = clip16((prod + (64'sd1 <<< 38)) >>> 39);
      else           r.offset_y = clip16((prod + (64'sd1 <<< 38)) >>> 39);
    end
    r.envelope = env[16:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t exp_w;
    if (!rst_ni) begin
      speed_q <= 11'd256; ease_q <= 1'b0; radius_q <= 15'd2048;
      loop_q <= 1'b0; shake_q <= 20'd131072; rest_q <= 20'd98304;
      fails = 0;
      checked = 0;
      offset_queue.delete();
    end else begin
      if (in_valid_i && !in_stall_i) offset_queue.push_back(wander_offset(in_word_i));
      if (out_valid_i && !out_stall_i) begin
        checked++;
        if (offset_queue.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected word %h", out_word_i);
        end else begin
          exp_w = offset_queue.pop_front();
          if (exp_w.offset_x !== out_word_i.offset_x || exp_w.offset_y !== out_word_i.offset_y
              || exp_w.envelope !== out_word_i.envelope) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: exp x=%0d y=%0d env=%0d got x=%0d y=%0d env=%0d",
                       exp_w.offset_x, exp_w.offset_y, exp_w.envelope,
                       out_word_i.offset_x, out_word_i.offset_y, out_word_i.envelope);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_HOP_SPEED:     speed_q  <= cfg_data_i[10:0];
          REG_EASE_MODE:     ease_q   <= cfg_data_i[0];
          REG_WANDER_RADIUS: radius_q <= cfg_data_i[14:0];
          REG_LOOP_ENABLE:   loop_q   <= cfg_data_i[0];
          REG_SHAKE_LENGTH:  shake_q  <= cfg_data_i;
          REG_REST_LENGTH:   rest_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== bench/glyph_wander_offset_core_tb.sv =====
// Top of the glyph wander offset bench: stimulus, register phases and verdict.
module glyph_wander_offset_core_tb;
  import gwo_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [19:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  in_t         in_word_i = '0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o, out_valid_o;
  out_t        out_word_o;
  int          fail_count, checked;
  int          cycles = 0;
  int          words_sent = 0;

  always #5 clk_i = ~clk_i;

  glyph_wander_offset_core dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_word_i,
    .out_valid_o, .out_stall_i, .out_word_o
  );

  glyph_wander_offset_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .in_word_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_word_i(out_word_o),
    .fail_count_o(fail_count), .checked_o(checked)
  );

  // Watchdog on total cycles.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // Receiver stall: random gap per word, with calm stretches (stall_mode 0).
  int stall_left = 0;
  int stall_mode = 1;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      if (out_valid_o && !out_stall_i) begin
        if ($urandom_range(0, 99) < 3) stall_mode = ~stall_mode & 1;
        if (stall_mode != 0 && $urandom_range(0, 2) != 0) begin
          stall_left <= $urandom_range(0, 16);
        end else begin
          stall_left <= 0;
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [19:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Drop valid, wait until every sent word came back, then let the pipeline settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (checked != words_sent) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Send one word; gap drawn per word, sometimes zero for back-to-back runs.
  task automatic send_word(logic [15:0] g, logic [31:0] t, bit use_gap);
    int gap;
    gap = use_gap ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= '{glyph_index: g, frame_time: t};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
  endtask

  // Random time: full range, small, near the 32-bit wrap of frame_time, or multiples of 16384.
  function automatic logic [31:0] pick_time();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 32'h000A_0000);
      2: return 32'hFFFF_FFFF - $urandom_range(0, 70000);
      default: return {16'($urandom_range(0, 20)), 16'(($urandom_range(0, 3)) * 16384)};
    endcase
  endfunction

  task automatic random_phase(int n);
    bit burst;
    burst = 1'b0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) burst = ~burst;
      send_word(16'($urandom()), pick_time(), !burst);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset registers, field extremes.
    send_word(16'h0000, 32'h0000_0000, 1'b0);
    send_word(16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    send_word(16'h5555, 32'h0001_0000, 1'b1);
    send_word(16'hAAAA, 32'h0000_8000, 1'b0);
    wait_idle();

    // Speed too low, bounce mode, radius of 25600, loop on with short burst and zero rest.
    write_reg(REG_HOP_SPEED, 20'd0);
    write_reg(REG_EASE_MODE, 20'd1);
    write_reg(REG_WANDER_RADIUS, 20'd25600);
    write_reg(REG_LOOP_ENABLE, 20'd1);
    write_reg(REG_SHAKE_LENGTH, 20'd0);
    write_reg(REG_REST_LENGTH, 20'd0);
    write_reg(3'd7, 20'hFFFFF);
    send_word(16'h1234, 32'h0000_0000, 1'b0);
    send_word(16'h1234, 32'h0000_0800, 1'b0);
    send_word(16'h1234, 32'h0000_1000, 1'b0);
    send_word(16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    wait_idle();

    // Out-of-range register bits and longest burst and rest.
    write_reg(REG_HOP_SPEED, 20'hFFFFF);
    write_reg(REG_WANDER_RADIUS, 20'hFFFFF);
    write_reg(REG_SHAKE_LENGTH, 20'hFFFFF);
    write_reg(REG_REST_LENGTH, 20'hFFFFF);
    send_word(16'h0F0F, 32'h0000_4000, 1'b0);
    send_word(16'hF0F0, 32'h000F_0000, 1'b0);
    send_word(16'h00FF, 32'h0010_0000, 1'b1);
    send_word(16'hFF00, 32'h7FFF_FFFF, 1'b0);
    wait_idle();

    // Random phases over several register settings.
    for (int ph = 0; ph < 9; ph++) begin
      write_reg(REG_HOP_SPEED, ph == 0 ? 20'd1280 : 20'($urandom_range(0, 1280)));
      write_reg(REG_EASE_MODE, 20'(ph % 2));
      write_reg(REG_WANDER_RADIUS, ph == 1 ? 20'd0 : 20'($urandom_range(0, 25600)));
      write_reg(REG_LOOP_ENABLE, 20'((ph / 2) % 2));
      write_reg(REG_SHAKE_LENGTH, ph == 2 ? 20'd655360 : 20'($urandom_range(0, 300000)));
      write_reg(REG_REST_LENGTH, ph == 3 ? 20'd0 : 20'($urandom_range(0, 655360)));
      random_phase(148);
      wait_idle();
    end

    $display("sent %0d words over 12 register settings, checked %0d results",
             words_sent, checked);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d failures", fail_count);
      $display("status: fail");
    end
    $finish;
  end
endmodule
